// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the byte-stream hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sha_pkg.sv =====
// Constants, types and helper functions of the SHA-256 byte-stream hasher.
`default_nettype none

package sha_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 3;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [BYTE_W-1:0] PAD_MARK      = 8'h80;
  localparam logic [5:0]        LENGTH_OFFSET = 6'd56;
  localparam logic [5:0]        LAST_SLOT     = 6'd63;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

`default_nettype wire

// ===== sv/sha_byte_if.sv =====
// Input channel of the hasher: one message byte with its flags per transaction.
`default_nettype none

interface sha_byte_if import sha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== sv/sha_digest_if.sv =====
// Output channel of the hasher: one digest word with its position per transaction.
`default_nettype none

interface sha_digest_if import sha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ===== sv/sha256_byte_stream_hasher.sv =====
// Flow: a byte transaction is taken in the idle state; the byte that completes a 64-byte block
//   starts a compression (prime, round steps on the word memory, final add).
// Throughput: bytes stream at one per cycle while idle; input stalls in compression, padding, output.
// End of message: mark, zero and length pad bytes with one or two compressions, then 8 digest words.
// Reset (rst, synchronous): hash words to the initial values, counts to zero, output idle.
`default_nettype none
`include "assert_macros.svh"

module sha256_byte_stream_hasher import sha_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  sha_byte_if.sink      byte_in,
  sha_digest_if.source  digest_out
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD_MARK, S_PAD_ZERO, S_PAD_LEN, S_PRIME, S_RUN, S_FINAL, S_OUT
  } state_t;

  state_t            state;
  state_t            ret_state;
  word_t             hash [8];
  word_t             v [8];
  logic [5:0]        fill;
  logic [63:0]       count;
  logic [63:0]       len;
  logic [2:0]        lidx;
  logic [6:0]        cnt;
  logic [23:0]       col;
  word_t             w1, w2, wk, wm16;
  word_t             out_word;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;
  logic              out_valid;

  // Word memory: block buffer while filling, rolling schedule while compressing.
  word_t             wmem [16];
  word_t             rd_a, rd_b;
  logic              we;
  logic [3:0]        waddr, addr_a, addr_b;
  word_t             wdata;

  logic              in_fire, out_fire;
  logic              absorb_en;
  logic [BYTE_W-1:0] absorb_byte;
  logic [63:0]       count_plus;
  word_t             w_new, t1, t2, ch, maj;

  assign in_fire  = byte_in.valid && byte_in.ready;
  assign out_fire = digest_out.valid && digest_out.ready;

  assign byte_in.ready          = (state == S_IDLE);
  assign digest_out.valid       = out_valid;
  assign digest_out.digest_word = out_word;
  assign digest_out.word_index  = out_idx;
  assign digest_out.last_word   = out_last;

  assign count_plus = count + {63'd0, byte_in.has_byte};

  always_comb begin
    absorb_en = 1'b0;
    absorb_byte = '0;
    unique case (state)
      S_IDLE: begin
        absorb_en = in_fire && byte_in.has_byte;
        absorb_byte = byte_in.data_byte;
      end
      S_PAD_MARK: begin
        absorb_en = 1'b1;
        absorb_byte = PAD_MARK;
      end
      S_PAD_ZERO: absorb_en = (fill != LENGTH_OFFSET);
      S_PAD_LEN: begin
        absorb_en = 1'b1;
        absorb_byte = len[63:56];
      end
      default: absorb_en = 1'b0;
    endcase
  end

  // Schedule step: the first 16 words come straight from the buffer.
  always_comb begin
    if (cnt[6:4] == 3'd0) begin
      w_new = rd_b;
    end else begin
      w_new = wm16 + small_sig0(rd_a) + rd_b + small_sig1(w2);
    end
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + big_sig1(v[4]) + ch + wk;
    t2  = big_sig0(v[0]) + maj;
  end

  // Reads run ahead through the rd_a/rd_b registers: port A fetches w[s-15], port B w[s-7] or the buffer word.
  always_comb begin
    we = 1'b0;
    waddr = fill[5:2];
    wdata = {col, absorb_byte};
    addr_a = cnt[3:0] + 4'd2;
    addr_b = (cnt[5:0] < 6'd15) ? cnt[3:0] + 4'd1 : cnt[3:0] + 4'd10;
    if (state == S_RUN) begin
      we = !cnt[6];
      waddr = cnt[3:0];
      wdata = w_new;
    end else begin
      we = absorb_en && (fill[1:0] == 2'd3);
    end
    if (state == S_PRIME) begin
      addr_a = 4'd1;
      addr_b = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wmem[waddr] <= wdata;
    end
    rd_a <= wmem[addr_a];
    rd_b <= wmem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= INIT_HASH[i];
      end
      fill <= '0;
      count <= '0;
      lidx <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
      out_idx <= '0;
      out_last <= 1'b0;
    end else begin
      if (absorb_en) begin
        col <= {col[15:0], absorb_byte};
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            count <= byte_in.end_of_message ? 64'd0 : count_plus;
            len <= {count_plus[60:0], 3'b000};
            if (absorb_en && fill == LAST_SLOT) begin
              state <= S_PRIME;
              ret_state <= byte_in.end_of_message ? S_PAD_MARK : S_IDLE;
            end else if (byte_in.end_of_message) begin
              state <= S_PAD_MARK;
            end
          end
        end
        S_PAD_MARK: begin
          if (fill == LAST_SLOT) begin
            state <= S_PRIME;
            ret_state <= S_PAD_ZERO;
          end else begin
            state <= S_PAD_ZERO;
          end
        end
        S_PAD_ZERO: begin
          if (fill == LENGTH_OFFSET) begin
            state <= S_PAD_LEN;
            lidx <= '0;
          end else if (fill == LAST_SLOT) begin
            state <= S_PRIME;
            ret_state <= S_PAD_ZERO;
          end
        end
        S_PAD_LEN: begin
          len <= {len[55:0], 8'd0};
          lidx <= lidx + 3'd1;
          if (lidx == 3'd7) begin
            state <= S_PRIME;
            ret_state <= S_OUT;
          end
        end
        S_PRIME: begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= hash[i];
          end
          cnt <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          cnt <= cnt + 7'd1;
          wm16 <= rd_a;
          if (!cnt[6]) begin
            wk <= w_new + ROUND_K[cnt[5:0]];
            w1 <= w_new;
            w2 <= w1;
          end
          // Round stage trails the schedule through the wk register.
          if (cnt != 7'd0) begin
            v[0] <= t1 + t2;
            v[1] <= v[0];
            v[2] <= v[1];
            v[3] <= v[2];
            v[4] <= v[3] + t1;
            v[5] <= v[4];
            v[6] <= v[5];
            v[7] <= v[6];
          end
          if (cnt == 7'd64) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          if (ret_state == S_OUT) begin
            out_word <= hash[0] + v[0];
            out_idx <= '0;
            out_last <= 1'b0;
            out_valid <= 1'b1;
          end
          state <= ret_state;
        end
        S_OUT: begin
          if (out_fire) begin
            if (out_last) begin
              out_valid <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= INIT_HASH[i];
              end
              state <= S_IDLE;
            end else begin
              out_word <= hash[out_idx + 3'd1];
              out_idx <= out_idx + 3'd1;
              out_last <= (out_idx == 3'd6);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_SAME(a_no_overlap, byte_in.ready, !out_valid, "input open while digest pending")
  `ASSERT_SAME(a_run_bound, state == S_RUN, cnt <= 7'd64, "round counter overran")
  `ASSERT_SAME(a_out_empty_buf, out_valid, fill == 6'd0, "digest shown with bytes buffered")
  `ASSERT_NEXT(a_last_drop, out_fire && out_last, !out_valid && state == S_IDLE,
               "digest not closed after last word")
  `ASSERT_SAME(a_last_idx, out_valid && out_last, out_idx == 3'd7, "last flag off word 7")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench of the SHA-256 byte-stream hasher with a built-in digest predictor.
module tb_top import sha_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TOTAL_ITEMS  = 210;
  localparam int unsigned EDGE_LENGTHS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam int         LEN_SLOT    = 56;
  localparam int         BLOCK_SIZE  = 64;

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              end_of_message;
  } byte_txn_t;

  typedef struct packed {
    word_t            digest_word;
    logic [IDX_W-1:0] word_index;
    logic             last_word;
  } digest_txn_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha_byte_if   byte_ch ();
  sha_digest_if digest_ch ();

  sha256_byte_stream_hasher dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_ch),
    .digest_out (digest_ch)
  );

  always #10 clk = ~clk;

  // Predictor state: running hash of the open message.
  word_t       msg_hash [8] = SHA_H0;
  logic [7:0]  blk_bytes [64];
  int          blk_fill = 0;
  logic [63:0] msg_len = '0;

  byte_txn_t   message_bytes [$];
  digest_txn_t digest_queue [$];
  byte_txn_t   cur_txn;

  int unsigned byte_txns_taken   = 0;
  int unsigned digest_words_due  = 0;
  int unsigned digest_words_seen = 0;
  int unsigned fail_count        = 0;
  int unsigned cycle_count       = 0;
  int unsigned total_txns        = 0;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    a = msg_hash[0]; b = msg_hash[1]; c = msg_hash[2]; d = msg_hash[3];
    e = msg_hash[4]; f = msg_hash[5]; g = msg_hash[6]; h = msg_hash[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    msg_hash[0] += a; msg_hash[1] += b; msg_hash[2] += c; msg_hash[3] += d;
    msg_hash[4] += e; msg_hash[5] += f; msg_hash[6] += g; msg_hash[7] += h;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk_bytes[blk_fill] = b;
    blk_fill++;
    if (blk_fill == BLOCK_SIZE) begin
      compress_block();
      blk_fill = 0;
    end
  endfunction

  // Advance the running hash by one byte transaction; queue the digest on end of message.
  function automatic void hash_byte_txn(input byte_txn_t t);
    logic [63:0] bit_len;
    digest_txn_t rec;
    if (t.has_byte) begin
      absorb_byte(t.data_byte);
      msg_len++;
    end
    if (t.end_of_message) begin
      bit_len = msg_len << 3;
      absorb_byte(PAD_BYTE);
      while (blk_fill != LEN_SLOT)
        absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
        absorb_byte(bit_len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        rec.digest_word = msg_hash[i];
        rec.word_index  = IDX_W'(i);
        rec.last_word   = (i == 7);
        digest_queue = {digest_queue, rec};
      end
      msg_hash = SHA_H0;
      blk_fill = 0;
      msg_len  = '0;
    end
  endfunction

  function automatic void push_txn(input logic [7:0] data, input logic has, input logic eom);
    byte_txn_t t;
    t.data_byte      = data;
    t.has_byte       = has;
    t.end_of_message = eom;
    message_bytes = {message_bytes, t};
  endfunction

  // Driver: bursts of byte transactions separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    byte_txn_t nxt;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        hash_byte_txn(cur_txn);
        byte_txns_taken <= byte_txns_taken + 1;
        if (cur_txn.end_of_message)
          digest_words_due <= digest_words_due + 8;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (message_bytes.size() > 0) begin
          nxt = message_bytes.pop_front();
          cur_txn = nxt;
          byte_ch.valid          <= 1'b1;
          byte_ch.data_byte      <= nxt.data_byte;
          byte_ch.has_byte       <= nxt.has_byte;
          byte_ch.end_of_message <= nxt.end_of_message;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern in phases, plus one long hold-off to back up the input.
  rx_mode_t    rx_mode    = RX_STEADY;
  int unsigned phase_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      digest_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      digest_ch.ready <= 1'b0;
    end else if (!hold_done && digest_words_seen >= 16 && digest_ch.valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      digest_ch.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      case (rx_mode)
        RX_STEADY: digest_ch.ready <= 1'b1;
        RX_COIN:   digest_ch.ready <= ($urandom_range(0, 1) == 1);
        default:   digest_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each digest transaction with the oldest predicted word.
  always @(posedge clk) begin
    digest_txn_t exp_word;
    if (!rst && digest_ch.valid && digest_ch.ready) begin
      digest_words_seen <= digest_words_seen + 1;
      if (digest_queue.size() == 0) begin
        $error("digest_word %h arrived with no digest pending", digest_ch.digest_word);
        fail_count++;
      end else begin
        exp_word = digest_queue.pop_front();
        if (digest_ch.digest_word !== exp_word.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_word.digest_word,
                 digest_ch.digest_word);
          fail_count++;
        end
        if (digest_ch.word_index !== exp_word.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_word.word_index,
                 digest_ch.word_index);
          fail_count++;
        end
        if (digest_ch.last_word !== exp_word.last_word) begin
          $error("last_word: expected %b, got %b", exp_word.last_word, digest_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned body_len;
    bit          close_on_byte;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.has_byte       = 1'b0;
    byte_ch.end_of_message = 1'b0;
    digest_ch.ready        = 1'b0;

    // Empty message closed by an empty final transaction.
    push_txn(8'h3c, 1'b0, 1'b1);
    // Idle transaction, then a single 0xff byte that also closes the message.
    push_txn(8'ha5, 1'b0, 1'b0);
    push_txn(8'hff, 1'b1, 1'b1);
    // "abc" with an idle in the middle, end mark on the last byte.
    push_txn(8'h61, 1'b1, 1'b0);
    push_txn(8'h5a, 1'b0, 1'b0);
    push_txn(8'h62, 1'b1, 1'b0);
    push_txn(8'h63, 1'b1, 1'b1);
    // Single zero byte, closed by an empty final transaction.
    push_txn(8'h00, 1'b1, 1'b0);
    push_txn(8'hff, 1'b0, 1'b1);
    // Alternating bit patterns, then a byte equal to the pad mark.
    push_txn(8'h55, 1'b1, 1'b0);
    push_txn(8'haa, 1'b1, 1'b0);
    push_txn(8'h80, 1'b1, 1'b1);

    // Random messages up to the transaction budget: mostly short, some sized around
    // the padding and block boundaries.
    while (message_bytes.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 6)
        body_len = $urandom_range(0, 12);
      else
        body_len = EDGE_LENGTHS[$urandom_range(0, 8)];
      if (body_len > TOTAL_ITEMS - message_bytes.size())
        body_len = TOTAL_ITEMS - message_bytes.size();
      close_on_byte = (body_len > 0) && $urandom_range(0, 1);
      for (int unsigned i = 0; i < body_len; i++) begin
        if ($urandom_range(0, 11) == 0)
          push_txn(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_txn(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == body_len - 1));
      end
      if (!close_on_byte)
        push_txn(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    total_txns = message_bytes.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (byte_txns_taken != total_txns) @(posedge clk);
    while (digest_words_seen < digest_words_due) @(posedge clk);
    // Hold to catch any stray digest words.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digest_queue.size() != 0) begin
      $error("%0d predicted digest words never arrived", digest_queue.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sha256_byte_stream_hasher.f =====
+incdir+sv
sv/sha_pkg.sv
sv/sha_byte_if.sv
sv/sha_digest_if.sv
sv/sha256_byte_stream_hasher.sv
test/tb_top.sv
